FILE: src/key_tag_pair_sorter_core_assert.svh
// Assertion macros shared by the sorter modules
`ifndef KEY_TAG_PAIR_SORTER_CORE_ASSERT_SVH
`define KEY_TAG_PAIR_SORTER_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define KTPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication
`define KTPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: src/ktps_pkg.sv
`default_nettype none
package ktps_pkg;
	localparam int unsigned KEY_W = 32;
	localparam int unsigned TAG_W = 32;

	typedef struct packed {
		logic load;      // shift a word into the cell chain
		logic drain;     // pop the head of the chain
		logic clear;     // empty the chain
	} ktps_cmd_t;

	typedef struct packed {
		logic full;
		logic last_one;  // exactly one entry left
	} ktps_stat_t;
endpackage
`default_nettype wire

FILE: src/ktps_datapath.sv
`default_nettype none
`include "key_tag_pair_sorter_core_assert.svh"
module ktps_datapath #(
	parameter int unsigned MAX_ITEMS = 64
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire ktps_pkg::ktps_cmd_t    cmd,
	output ktps_pkg::ktps_stat_t        stat,
	input  wire logic                   descending,
	input  wire logic [31:0]            in_key,
	input  wire logic [31:0]            in_tag,
	output logic      [31:0]            head_key,
	output logic      [31:0]            head_tag
);
	import ktps_pkg::*;

	localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

	// Cell chain kept sorted: cell 0 is the head (next to leave).
	// The chain is ordered on arrival, so descending must hold steady for a whole set.
	logic [KEY_W-1:0] key_q [MAX_ITEMS];
	logic [TAG_W-1:0] tag_q [MAX_ITEMS];
	logic [MAX_ITEMS-1:0] occ_q;
	logic [CW-1:0]    cnt_q;
	logic [MAX_ITEMS-1:0] nb; // new word goes before cell i

	always_comb begin
		for (int i = 0; i < MAX_ITEMS; i++) begin
			// strict compare keeps equal keys in load order
			if (!occ_q[i])
				nb[i] = 1'b1;
			else if (descending)
				nb[i] = $signed(in_key) > $signed(key_q[i]);
			else
				nb[i] = $signed(in_key) < $signed(key_q[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.clear) begin
				occ_q <= '0;
				cnt_q <= '0;
			end else if (cmd.load) begin
				occ_q <= {occ_q[MAX_ITEMS-2:0], 1'b1};
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.drain) begin
				occ_q <= {1'b0, occ_q[MAX_ITEMS-1:1]};
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_ITEMS; i++) begin
			if (cmd.load) begin
				if (i == 0) begin
					if (nb[0]) begin
						key_q[0] <= in_key;
						tag_q[0] <= in_tag;
					end
				end else if (nb[i]) begin
					if (!nb[i-1]) begin
						key_q[i] <= in_key;
						tag_q[i] <= in_tag;
					end else begin
						key_q[i] <= key_q[i-1];
						tag_q[i] <= tag_q[i-1];
					end
				end
			end else if (cmd.drain) begin
				if (i < MAX_ITEMS - 1) begin
					key_q[i] <= key_q[i+1];
					tag_q[i] <= tag_q[i+1];
				end
			end
		end
	end

	assign stat.full     = (cnt_q == CW'(MAX_ITEMS));
	assign stat.last_one = (cnt_q == CW'(1));
	assign head_key = key_q[0];
	assign head_tag = tag_q[0];

	`KTPS_ASSERT_IMP(a_no_load_full, clk, arst_n, cmd.load, !stat.full)
	`KTPS_ASSERT_IMP(a_occ_match, clk, arst_n, 1'b1, $countones(occ_q) == int'(cnt_q))
	`KTPS_ASSERT_NEXT(a_clear_empty, clk, arst_n, cmd.clear, cnt_q == '0)
endmodule
`default_nettype wire

FILE: src/ktps_ctrl.sv
`default_nettype none
`include "key_tag_pair_sorter_core_assert.svh"
module ktps_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 in_last,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      out_last_flag,
	output logic                      ovf,
	output ktps_pkg::ktps_cmd_t       cmd,
	input  wire ktps_pkg::ktps_stat_t stat
);
	import ktps_pkg::*;

	typedef enum logic {S_LOAD, S_DRAIN} state_t;
	state_t state_q;
	logic   ovf_q;
	logic   acc, take;

	assign in_stall = (state_q != S_LOAD);
	assign acc      = in_valid && !in_stall;
	assign out_valid = (state_q == S_DRAIN);
	assign take     = out_valid && !out_stall;
	assign out_last_flag = stat.last_one;
	assign ovf = ovf_q;

	always_comb begin
		cmd = '0;
		cmd.load    = acc && !stat.full;
		cmd.drain   = take;
		cmd.clear   = take && stat.last_one;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (acc && stat.full)
						ovf_q <= 1'b1;
					if (acc && in_last)
						state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (take && stat.last_one) begin
						state_q <= S_LOAD;
						ovf_q   <= 1'b0;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	`KTPS_ASSERT_IMP(a_no_accept_drain, clk, arst_n, state_q == S_DRAIN, !acc)
	`KTPS_ASSERT_NEXT(a_back_to_load, clk, arst_n, take && stat.last_one, state_q == S_LOAD)
	`KTPS_ASSERT_IMP(a_drain_nonempty, clk, arst_n, out_valid, !(stat.full && stat.last_one))
endmodule
`default_nettype wire

FILE: src/key_tag_pair_sorter_core.sv
`default_nettype none
// Stable key/tag sorter. Words are loaded one per cycle into a sorted cell chain
// (insertion on arrival, strict signed compare so equal keys keep load order);
// the word with is_last starts the burst, during which the input is stalled and
// results leave one per cycle from the head of the chain while out_stall is low. Words
// beyond MAX_ITEMS are dropped and flag overflow on every result of that set. The chain
// is ordered as words arrive, so descending must only be written between sets.
module key_tag_pair_sorter_core #(
	parameter int unsigned MAX_ITEMS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] sort_key,
	input  wire logic [31:0] tag,
	input  wire logic        is_last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      out_key,
	output logic [31:0]      out_tag,
	output logic             out_last,
	output logic             overflow
);
	import ktps_pkg::*;

	logic       descending_q;
	ktps_cmd_t  cmd;
	ktps_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			descending_q <= 1'b0;
		else if (cfg_we)
			descending_q <= cfg_wdata;
	end

	ktps_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_last(is_last),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_last_flag(out_last), .ovf(overflow),
		.cmd(cmd), .stat(stat)
	);

	ktps_datapath #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.descending(descending_q), .in_key(sort_key), .in_tag(tag),
		.head_key(out_key), .head_tag(out_tag)
	);
endmodule
`default_nettype wire

FILE: tb/tb_key_tag_pair_sorter_core.sv
`default_nettype none
module tb_key_tag_pair_sorter_core;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] tag;
		logic        last;
	} pair_word_t;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] tag;
		logic        last;
		logic        ovf;
	} sorted_word_t;

	localparam int unsigned CAPACITY = 64;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] sort_key = '0;
	logic [31:0] tag = '0;
	logic        is_last = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] out_key;
	logic [31:0] out_tag;
	logic        out_last;
	logic        overflow;

	key_tag_pair_sorter_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.sort_key(sort_key), .tag(tag), .is_last(is_last),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_key(out_key), .out_tag(out_tag), .out_last(out_last), .overflow(overflow)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	pair_word_t   pending_words[$];
	sorted_word_t sorted_due[$];
	pair_word_t   set_pairs[$];
	logic         sort_desc = 1'b0;
	logic         set_dropped = 1'b0;
	bit           in_taken = 1'b0;
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;
	int           hold_asked = 0;
	int           hold_done = 0;
	int           hold_cnt = 0;
	int           errors = 0;
	int           words_in = 0;
	int           words_out = 0;
	int           sets_done = 0;
	int           ovf_sets = 0;

	// close the set: stable insertion sort in the latched direction
	task automatic close_set();
		pair_word_t sorted[$];
		pair_word_t p;
		int j;
		sorted_word_t r;
		foreach (set_pairs[i]) begin
			p = set_pairs[i];
			j = sorted.size();
			while (j > 0 && (sort_desc ? ($signed(p.key) > $signed(sorted[j-1].key))
					: ($signed(p.key) < $signed(sorted[j-1].key))))
				j--;
			sorted.insert(j, p);
		end
		foreach (sorted[i]) begin
			r.key = sorted[i].key;
			r.tag = sorted[i].tag;
			r.last = (i == sorted.size() - 1);
			r.ovf = set_dropped;
			sorted_due.push_back(r);
		end
		if (set_dropped)
			ovf_sets++;
		sets_done++;
		set_pairs.delete();
		set_dropped = 1'b0;
	endtask

	// predictor and result checker
	always @(posedge clk) begin
		sorted_word_t e;
		pair_word_t w;
		in_taken = 1'b0;
		if (arst_n) begin
			if (cfg_we)
				sort_desc = cfg_wdata;
			if (in_valid && !in_stall) begin
				in_taken = 1'b1;
				words_in++;
				w.key = sort_key;
				w.tag = tag;
				w.last = is_last;
				if (set_pairs.size() < CAPACITY)
					set_pairs.push_back(w);
				else
					set_dropped = 1'b1;
				if (is_last)
					close_set();
			end
			if (out_valid && !out_stall) begin
				words_out++;
				if (sorted_due.size() == 0) begin
					$display("%0t: unexpected word key=%h tag=%h last=%b ovf=%b",
						$time, out_key, out_tag, out_last, overflow);
					errors++;
				end else begin
					e = sorted_due.pop_front();
					if (out_key !== e.key || out_tag !== e.tag || out_last !== e.last
							|| overflow !== e.ovf) begin
						$display("%0t: mismatch expected key=%h tag=%h last=%b ovf=%b, got key=%h tag=%h last=%b ovf=%b",
							$time, e.key, e.tag, e.last, e.ovf,
							out_key, out_tag, out_last, overflow);
						errors++;
					end
				end
			end
		end
	end

	// sender: payload held until the word is taken
	always @(negedge clk) begin
		pair_word_t w;
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				w = pending_words.pop_front();
				in_valid <= 1'b1;
				sort_key <= w.key;
				tag <= w.tag;
				is_last <= w.last;
			end else
				in_valid <= 1'b0;
		end
	end

	// receiver stall, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_asked != hold_done) begin
			hold_done = hold_asked;
			hold_cnt = 400;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic queue_set(int n, int spread);
		pair_word_t w;
		for (int i = 0; i < n; i++) begin
			w.key = (spread == 0) ? $urandom : $urandom_range(2 * spread) - spread;
			w.tag = $urandom;
			w.last = (i == n - 1);
			pending_words.push_back(w);
		end
	endtask

	task automatic queue_word(logic [31:0] k, logic [31:0] t, logic l);
		pair_word_t w;
		w.key = k;
		w.tag = t;
		w.last = l;
		pending_words.push_back(w);
	endtask

	task automatic wait_drained();
		while (pending_words.size() > 0 || in_valid || sorted_due.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_dir(logic d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_sets(int words);
		int n;
		int r;
		int total;
		total = 0;
		while (total < words) begin
			r = $urandom_range(99);
			if (r < 6)
				n = $urandom_range(CAPACITY + 1, CAPACITY + 4);
			else if (r < 12)
				n = CAPACITY;
			else
				n = $urandom_range(1, 12);
			queue_set(n, ($urandom_range(2) == 0) ? 3 : 0);
			total += n;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, single word, equal keys, both directions
		send_idle_pct = 7;
		recv_idle_pct = 78;
		queue_word(32'h7fffffff, 32'hffffffff, 1'b1);
		queue_word(32'h80000000, 32'h00000000, 1'b0);
		queue_word(32'h7fffffff, 32'h00000001, 1'b0);
		queue_word(32'h00000000, 32'h80000000, 1'b0);
		queue_word(32'hffffffff, 32'h7fffffff, 1'b0);
		queue_word(32'h00000005, 32'h0000000a, 1'b0);
		queue_word(32'h00000005, 32'h0000000b, 1'b0);
		queue_word(32'h00000005, 32'h0000000c, 1'b1);
		wait_drained();
		write_dir(1'b1);
		queue_word(32'h00000005, 32'h0000000a, 1'b0);
		queue_word(32'h80000000, 32'h55555555, 1'b0);
		queue_word(32'h00000005, 32'h0000000b, 1'b0);
		queue_word(32'h7fffffff, 32'haaaaaaaa, 1'b0);
		queue_word(32'hffffffff, 32'h12345678, 1'b0);
		queue_word(32'h00000005, 32'h0000000c, 1'b1);
		wait_drained();
		write_dir(1'b0);

		random_sets(90);
		wait_drained();

		send_idle_pct = 78;
		recv_idle_pct = 7;
		write_dir(1'b1);
		random_sets(80);
		wait_drained();

		// no idling; long receiver hold-off over a full set plus following words
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_dir(1'b0);
		hold_asked++;
		queue_set(CAPACITY, 0);
		queue_set(5, 3);
		random_sets(40);
		wait_drained();
		write_dir(1'b1);
		random_sets(30);
		wait_drained();

		$display("%0d words in, %0d sorted words out, %0d sets (%0d with dropped words)",
			words_in, words_out, sets_done, ovf_sets);
		$display("both directions, signed extremes, equal keys and full-store overflow exercised");
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#40000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire

FILE: sim.f
+incdir+src
src/ktps_pkg.sv
src/ktps_datapath.sv
src/ktps_ctrl.sv
src/key_tag_pair_sorter_core.sv
tb/tb_key_tag_pair_sorter_core.sv
